@@ rtl/assert_macros.svh @@
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define TBWA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked assertion, also checked during reset
`define TBWA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ rtl/tbwa_pkg.sv @@
`timescale 1ns / 1ps

package tbwa_pkg;

  localparam int TABLE_TILES = 1024;
  localparam int WORKERS     = 16;

  localparam int CFG_W   = 11;
  localparam int COORD_W = 10;
  localparam int WID_W   = 4;
  localparam int ENT_W   = WID_W + 1;
  localparam int PROD_W  = 2 * CFG_W;
  localparam int ADDR_W  = (TABLE_TILES > 1) ? $clog2(TABLE_TILES) : 1;
  localparam int WK_RAW  = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int WK_W    = (WK_RAW > WID_W) ? WID_W : WK_RAW;
  localparam int DIV_CNT_W = $clog2(CFG_W + 1);
  localparam int IDX_W   = 2;

  typedef enum logic {
    OP_CLAIM     = 1'b0,
    OP_NEW_FRAME = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_GRANT   = 2'd0,
    ST_DONE    = 2'd1,
    ST_TOOBIG  = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  typedef enum logic [IDX_W-1:0] {
    REG_GRID_W  = 2'd0,
    REG_GRID_H  = 2'd1,
    REG_BLOCK_W = 2'd2,
    REG_BLOCK_H = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MUL_WH = 2'd0,
    MUL_YW = 2'd1,
    MUL_JW = 2'd2
  } mul_sel_t;

  typedef struct packed {
    op_t              operation;
    logic [WID_W-1:0] worker_id;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [COORD_W-1:0] tile_x;
    logic [COORD_W-1:0] tile_y;
  } rsp_t;

  typedef struct packed {
    logic     item_ld;
    logic     wk_rd;
    logic     wk_clr;
    logic     prod_ld;
    mul_sel_t mul_sel;
    logic     cur_first;
    logic     cur_resume;
    logic     cur_step;
    logic     mem_clr;
    logic     mem_rd;
    logic     mem_fill;
    logic     div_start;
    logic     div_sel;
    logic     left_ld;
    logic     top_ld;
    logic     bound_ld;
    logic     col_init;
    logic     col_step;
    logic     row_step;
    logic     wb_done;
    logic     wb_grant;
    logic     res_ld;
    status_t  res_status;
  } cmd_t;

  typedef struct packed {
    logic op_new;
    logic too_big;
    logic bad;
    logic started;
    logic cur_fin;
    logic y_past;
    logic ent_valid;
    logic ent_own;
    logic div_done;
    logic row_end;
    logic col_last;
    logic clr_last;
    logic out_full;
  } sts_t;

endpackage

@@ rtl/tbwa_div.sv @@
`timescale 1ns / 1ps

module tbwa_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tbwa_pkg::CFG_W-1:0] dividend,
  input  logic [tbwa_pkg::CFG_W-1:0] divisor,
  output logic                       done,
  output logic [tbwa_pkg::CFG_W-1:0] rem
);

  logic                           busy;
  logic [tbwa_pkg::DIV_CNT_W-1:0] cnt;
  logic [tbwa_pkg::CFG_W-1:0]     sh;
  logic [tbwa_pkg::CFG_W-1:0]     d;
  logic [tbwa_pkg::CFG_W-1:0]     r;
  logic [tbwa_pkg::CFG_W:0]       trial;

  // one quotient bit a cycle, remainder only
  assign trial = {r, sh[tbwa_pkg::CFG_W-1]};
  assign rem   = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == tbwa_pkg::DIV_CNT_W'(tbwa_pkg::CFG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh <= dividend;
      d  <= divisor;
      r  <= '0;
    end else if (busy) begin
      sh <= sh << 1;
      if (trial >= {1'b0, d}) begin
        r <= tbwa_pkg::CFG_W'(trial - {1'b0, d});
      end else begin
        r <= trial[tbwa_pkg::CFG_W-1:0];
      end
    end
  end

endmodule

@@ rtl/tbwa_dp.sv @@
`timescale 1ns / 1ps

module tbwa_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tbwa_pkg::IDX_W-1:0] cfg_index,
  input  logic [tbwa_pkg::CFG_W-1:0] cfg_data,
  input  tbwa_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output tbwa_pkg::rsp_t             rsp,
  input  tbwa_pkg::cmd_t             cmd,
  output tbwa_pkg::sts_t             sts
);

  logic [tbwa_pkg::CFG_W-1:0] grid_w;
  logic [tbwa_pkg::CFG_W-1:0] grid_h;
  logic [tbwa_pkg::CFG_W-1:0] blk_w;
  logic [tbwa_pkg::CFG_W-1:0] blk_h;
  logic [tbwa_pkg::CFG_W-1:0] bw_eff;
  logic [tbwa_pkg::CFG_W-1:0] bh_eff;

  tbwa_pkg::op_t              op_q;
  logic [tbwa_pkg::WID_W-1:0] wid_q;
  logic [tbwa_pkg::WK_W-1:0]  wk;

  logic [tbwa_pkg::WORKERS-1:0] started;
  logic [tbwa_pkg::COORD_W-1:0] cur_x [tbwa_pkg::WORKERS];
  logic [tbwa_pkg::CFG_W-1:0]   cur_y [tbwa_pkg::WORKERS];
  logic                         started_q;
  logic [tbwa_pkg::COORD_W-1:0] cx_q;
  logic [tbwa_pkg::CFG_W-1:0]   cy_q;

  logic [tbwa_pkg::CFG_W-1:0]  x;
  logic [tbwa_pkg::CFG_W-1:0]  y;
  logic [tbwa_pkg::CFG_W-1:0]  x_next;
  logic [tbwa_pkg::CFG_W-1:0]  y_next;
  logic [tbwa_pkg::CFG_W-1:0]  rx_inc;
  logic [tbwa_pkg::CFG_W-1:0]  sx_inc;

  logic [tbwa_pkg::CFG_W-1:0]  ma;
  logic [tbwa_pkg::CFG_W-1:0]  mb;
  logic [tbwa_pkg::PROD_W-1:0] prod;

  logic [tbwa_pkg::CFG_W-1:0] left;
  logic [tbwa_pkg::CFG_W-1:0] top;
  logic [tbwa_pkg::CFG_W-1:0] right;
  logic [tbwa_pkg::CFG_W-1:0] bottom;
  logic [tbwa_pkg::CFG_W-1:0] i;
  logic [tbwa_pkg::CFG_W-1:0] j;

  logic                       div_done;
  logic [tbwa_pkg::CFG_W-1:0] div_rem;
  logic [tbwa_pkg::CFG_W-1:0] div_a;
  logic [tbwa_pkg::CFG_W-1:0] div_b;

  logic [tbwa_pkg::ENT_W-1:0]  mem [tbwa_pkg::TABLE_TILES];
  logic [tbwa_pkg::ENT_W-1:0]  rdata;
  logic [tbwa_pkg::ADDR_W-1:0] addr;
  logic [tbwa_pkg::ADDR_W-1:0] clr_cnt;
  logic                        clr_last;

  assign bw_eff = (blk_w == '0) ? tbwa_pkg::CFG_W'(1) : blk_w;
  assign bh_eff = (blk_h == '0) ? tbwa_pkg::CFG_W'(1) : blk_h;
  assign wk     = wid_q[tbwa_pkg::WK_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_w <= tbwa_pkg::CFG_W'(1);
      grid_h <= tbwa_pkg::CFG_W'(1);
      blk_w  <= tbwa_pkg::CFG_W'(1);
      blk_h  <= tbwa_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      case (tbwa_pkg::cfg_reg_t'(cfg_index))
        tbwa_pkg::REG_GRID_W:  grid_w <= cfg_data;
        tbwa_pkg::REG_GRID_H:  grid_h <= cfg_data;
        tbwa_pkg::REG_BLOCK_W: blk_w  <= cfg_data;
        tbwa_pkg::REG_BLOCK_H: blk_h  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_ld) begin
      op_q  <= req.operation;
      wid_q <= req.worker_id;
    end
  end

  // per-worker state
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= '0;
    end else if (cmd.wk_clr) begin
      started <= '0;
    end else if (cmd.wb_done || cmd.wb_grant) begin
      started[wk] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb_done) begin
      cur_x[wk] <= '0;
      cur_y[wk] <= grid_h;
    end else if (cmd.wb_grant) begin
      cur_x[wk] <= x[tbwa_pkg::COORD_W-1:0];
      cur_y[wk] <= y;
    end
    if (cmd.wk_rd) begin
      started_q <= started[wk];
      cx_q      <= cur_x[wk];
      cy_q      <= cur_y[wk];
    end
  end

  // cursor advance in row-major order
  assign rx_inc = tbwa_pkg::CFG_W'(cx_q) + 1'b1;
  assign sx_inc = x + 1'b1;

  always_comb begin
    x_next = x;
    y_next = y;
    if (cmd.cur_first) begin
      x_next = '0;
      y_next = '0;
    end else if (cmd.cur_resume) begin
      if (rx_inc >= grid_w) begin
        x_next = '0;
        y_next = cy_q + 1'b1;
      end else begin
        x_next = rx_inc;
        y_next = cy_q;
      end
    end else if (cmd.cur_step) begin
      if (sx_inc >= grid_w) begin
        x_next = '0;
        y_next = y + 1'b1;
      end else begin
        x_next = sx_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    x <= x_next;
    y <= y_next;
  end

  always_comb begin
    case (cmd.mul_sel)
      tbwa_pkg::MUL_WH: begin
        ma = grid_w;
        mb = grid_h;
      end
      tbwa_pkg::MUL_YW: begin
        ma = y;
        mb = grid_w;
      end
      tbwa_pkg::MUL_JW: begin
        ma = j;
        mb = grid_w;
      end
      default: begin
        ma = grid_w;
        mb = grid_h;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_ld) begin
      prod <= tbwa_pkg::PROD_W'(ma) * tbwa_pkg::PROD_W'(mb);
    end
  end

  // meta-block corner and bounds
  assign div_a = cmd.div_sel ? y : x;
  assign div_b = cmd.div_sel ? bh_eff : bw_eff;

  tbwa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.left_ld) begin
      left <= x - div_rem;
    end
    if (cmd.top_ld) begin
      top <= y - div_rem;
    end
    if (cmd.bound_ld) begin
      right  <= ((grid_w - left) < bw_eff) ? grid_w : tbwa_pkg::CFG_W'(left + bw_eff);
      bottom <= ((grid_h - top) < bh_eff) ? grid_h : tbwa_pkg::CFG_W'(top + bh_eff);
      j      <= top;
    end else if (cmd.row_step) begin
      j <= j + 1'b1;
    end
    if (cmd.col_init) begin
      i <= left;
    end else if (cmd.col_step) begin
      i <= i + 1'b1;
    end
  end

  // ownership table
  always_comb begin
    if (cmd.mem_clr) begin
      addr = clr_cnt;
    end else if (cmd.mem_fill) begin
      addr = tbwa_pkg::ADDR_W'(prod) + tbwa_pkg::ADDR_W'(i);
    end else begin
      addr = tbwa_pkg::ADDR_W'(prod) + tbwa_pkg::ADDR_W'(x);
    end
  end

  assign clr_last = (clr_cnt == tbwa_pkg::ADDR_W'(tbwa_pkg::TABLE_TILES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.mem_clr) begin
      clr_cnt <= clr_last ? '0 : clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_clr) begin
      mem[addr] <= '0;
    end else if (cmd.mem_fill) begin
      mem[addr] <= {1'b1, wid_q};
    end
    if (cmd.mem_rd) begin
      rdata <= mem[addr];
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_ld) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      rsp.status <= cmd.res_status;
      if (cmd.res_status == tbwa_pkg::ST_GRANT) begin
        rsp.tile_x <= x[tbwa_pkg::COORD_W-1:0];
        rsp.tile_y <= y[tbwa_pkg::COORD_W-1:0];
      end else begin
        rsp.tile_x <= '0;
        rsp.tile_y <= '0;
      end
    end
  end

  always_comb begin
    sts.op_new    = (op_q == tbwa_pkg::OP_NEW_FRAME);
    sts.too_big   = (prod > tbwa_pkg::PROD_W'(tbwa_pkg::TABLE_TILES));
    sts.bad       = (grid_w == '0) || (grid_h == '0) || !(int'(wid_q) < tbwa_pkg::WORKERS);
    sts.started   = started_q;
    sts.cur_fin   = (cy_q >= grid_h);
    sts.y_past    = (y >= grid_h);
    sts.ent_valid = rdata[tbwa_pkg::ENT_W-1];
    sts.ent_own   = (rdata[tbwa_pkg::WID_W-1:0] == wid_q);
    sts.div_done  = div_done;
    sts.row_end   = (j >= bottom);
    sts.col_last  = (({1'b0, i} + 1'b1) >= {1'b0, right});
    sts.clr_last  = clr_last;
    sts.out_full  = rsp_valid && !rsp_ready;
  end

endmodule

@@ rtl/tbwa_ctrl.sv @@
`timescale 1ns / 1ps

module tbwa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  tbwa_pkg::sts_t sts,
  output tbwa_pkg::cmd_t cmd
);

  typedef enum logic [15:0] {
    S_CLEAR  = 16'b0000000000000001,
    S_NEWF   = 16'b0000000000000010,
    S_IDLE   = 16'b0000000000000100,
    S_LOAD   = 16'b0000000000001000,
    S_DECIDE = 16'b0000000000010000,
    S_SCAN   = 16'b0000000000100000,
    S_ADDR   = 16'b0000000001000000,
    S_RD     = 16'b0000000010000000,
    S_DIVX   = 16'b0000000100000000,
    S_DIVXW  = 16'b0000001000000000,
    S_DIVY   = 16'b0000010000000000,
    S_DIVYW  = 16'b0000100000000000,
    S_BOUND  = 16'b0001000000000000,
    S_FROW   = 16'b0010000000000000,
    S_FCOL   = 16'b0100000000000000,
    S_FINISH = 16'b1000000000000000
  } state_t;

  state_t             state;
  state_t             state_next;
  tbwa_pkg::status_t  code;
  tbwa_pkg::status_t  code_next;

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      code  <= tbwa_pkg::ST_DONE;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.mul_sel    = tbwa_pkg::MUL_WH;
    cmd.res_status = code;
    state_next     = state;
    code_next      = code;
    case (state)
      S_CLEAR: begin
        cmd.mem_clr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_NEWF: begin
        cmd.mem_clr = 1'b1;
        cmd.wk_clr  = 1'b1;
        if (sts.clr_last) begin
          code_next  = tbwa_pkg::ST_CLEARED;
          state_next = S_FINISH;
        end
      end
      S_IDLE: begin
        cmd.item_ld = req_valid;
        if (req_valid) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.prod_ld = 1'b1;
        cmd.mul_sel = tbwa_pkg::MUL_WH;
        cmd.wk_rd   = 1'b1;
        state_next  = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.op_new) begin
          state_next = S_NEWF;
        end else if (sts.too_big) begin
          code_next  = tbwa_pkg::ST_TOOBIG;
          state_next = S_FINISH;
        end else if (sts.bad) begin
          code_next  = tbwa_pkg::ST_DONE;
          state_next = S_FINISH;
        end else if (!sts.started) begin
          cmd.cur_first = 1'b1;
          state_next    = S_SCAN;
        end else if (sts.cur_fin) begin
          code_next  = tbwa_pkg::ST_DONE;
          state_next = S_FINISH;
        end else begin
          cmd.cur_resume = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.y_past) begin
          cmd.wb_done = 1'b1;
          code_next   = tbwa_pkg::ST_DONE;
          state_next  = S_FINISH;
        end else begin
          cmd.prod_ld = 1'b1;
          cmd.mul_sel = tbwa_pkg::MUL_YW;
          state_next  = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.mem_rd = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        if (!sts.ent_valid) begin
          state_next = S_DIVX;
        end else if (sts.ent_own) begin
          cmd.wb_grant = 1'b1;
          code_next    = tbwa_pkg::ST_GRANT;
          state_next   = S_FINISH;
        end else begin
          cmd.cur_step = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_DIVX: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b0;
        state_next    = S_DIVXW;
      end
      S_DIVXW: begin
        if (sts.div_done) begin
          cmd.left_ld = 1'b1;
          state_next  = S_DIVY;
        end
      end
      S_DIVY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        state_next    = S_DIVYW;
      end
      S_DIVYW: begin
        cmd.div_sel = 1'b1;
        if (sts.div_done) begin
          cmd.top_ld = 1'b1;
          state_next = S_BOUND;
        end
      end
      S_BOUND: begin
        cmd.bound_ld = 1'b1;
        state_next   = S_FROW;
      end
      S_FROW: begin
        if (sts.row_end) begin
          cmd.wb_grant = 1'b1;
          code_next    = tbwa_pkg::ST_GRANT;
          state_next   = S_FINISH;
        end else begin
          cmd.prod_ld  = 1'b1;
          cmd.mul_sel  = tbwa_pkg::MUL_JW;
          cmd.col_init = 1'b1;
          state_next   = S_FCOL;
        end
      end
      S_FCOL: begin
        cmd.mem_fill = 1'b1;
        cmd.col_step = 1'b1;
        if (sts.col_last) begin
          cmd.row_step = 1'b1;
          state_next   = S_FROW;
        end
      end
      S_FINISH: begin
        if (!sts.out_full) begin
          cmd.res_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

@@ rtl/tile_block_work_allocator.sv @@
`timescale 1ns / 1ps

// Tile work allocator: hands out the tiles of a grid to up to 16 workers, one
// request word in and one response word out over valid/ready, with four grid
// and meta-block size registers on a plain write port. After reset, and on
// every new-frame request, the ownership table is swept clear one entry a
// cycle while no request is taken; a new-frame request answers when the sweep
// ends. A claim visits tiles in turn, each with a cursor multiply, a table
// read and a check; a claim that lands on an unowned tile then works out the
// two bit-serial remainders of the meta-block corner and writes the table row
// by row over each tile of the meta-block. One word is worked on at a time;
// the next request is taken while the previous response waits.
module tile_block_work_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tbwa_pkg::IDX_W-1:0] cfg_index,
  input  logic [tbwa_pkg::CFG_W-1:0] cfg_data,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  tbwa_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output tbwa_pkg::rsp_t             rsp
);

  tbwa_pkg::cmd_t cmd;
  tbwa_pkg::sts_t sts;

  tbwa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tbwa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

@@ rtl/tbwa_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tbwa_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input tbwa_pkg::rsp_t rsp
);

  logic is_grant;
  logic coord_zero;

  assign is_grant   = (rsp.status == tbwa_pkg::ST_GRANT);
  assign coord_zero = (rsp.tile_x == '0) && (rsp.tile_y == '0);

  // stalled response word holds
  `TBWA_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))

  // only a grant carries coordinates
  `TBWA_ASSERT(a_coord_zero, clk, rst, rsp_valid && !is_grant |-> coord_zero)

  // table sweep after reset blocks requests
  `TBWA_ASSERT_ALWAYS(a_reset_busy, clk, rst |=> !req_ready)

  // an accepted request keeps the block busy next cycle
  `TBWA_ASSERT(a_busy_after_req, clk, rst, req_valid && req_ready |=> !req_ready)

endmodule

bind tile_block_work_allocator tbwa_checker u_tbwa_checker (.*);

@@ tb/tile_block_work_allocator_tb.sv @@
`timescale 1ns / 1ps

module tile_block_work_allocator_tb;
  import tbwa_pkg::*;

  logic     clk;
  logic     rst;
  logic     cfg_we;
  cfg_reg_t cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic     req_valid;
  logic     req_ready;
  req_t     req;
  logic     rsp_valid;
  logic     rsp_ready;
  rsp_t     rsp;

  tile_block_work_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // allocator mirror
  logic             own_valid [TABLE_TILES];
  logic [WID_W-1:0] own_id [TABLE_TILES];
  logic             started [WORKERS];
  int unsigned      cur_x [WORKERS];
  int unsigned      cur_y [WORKERS];
  int unsigned      grid_w, grid_h, blk_w, blk_h;

  rsp_t        tile_answers_q [$];
  rsp_t        want;
  int unsigned sent_items;
  int unsigned errors;
  bit          idle_on;
  int unsigned hold_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void clear_frame();
    for (int i = 0; i < TABLE_TILES; i++) begin
      own_valid[i] = 1'b0;
      own_id[i] = '0;
    end
    for (int i = 0; i < WORKERS; i++) begin
      started[i] = 1'b0;
      cur_x[i] = 0;
      cur_y[i] = 0;
    end
  endfunction

  function automatic rsp_t predict_alloc(input req_t r);
    rsp_t        res;
    int unsigned w, h, bw, bh, x, y, idx, wid;
    int unsigned left, top, right, bottom;
    bit          hit;
    w = grid_w;
    h = grid_h;
    bw = (blk_w == 0) ? 1 : blk_w;
    bh = (blk_h == 0) ? 1 : blk_h;
    wid = r.worker_id;
    res = '{status: ST_DONE, tile_x: '0, tile_y: '0};
    if (r.operation == OP_NEW_FRAME) begin
      clear_frame();
      res.status = ST_CLEARED;
      return res;
    end
    if (w * h > TABLE_TILES) begin
      res.status = ST_TOOBIG;
      return res;
    end
    if (w == 0 || h == 0) return res;
    if (!started[wid]) begin
      x = 0;
      y = 0;
      started[wid] = 1'b1;
    end else begin
      x = cur_x[wid];
      y = cur_y[wid];
      if (y >= h) return res;
      x++;
      if (x >= w) begin
        x = 0;
        y++;
      end
    end
    hit = 1'b0;
    while (y < h && !hit) begin
      idx = y * w + x;
      if (!own_valid[idx]) begin
        left = (x / bw) * bw;
        top = (y / bh) * bh;
        right = (w - left < bw) ? w : left + bw;
        bottom = (h - top < bh) ? h : top + bh;
        for (int unsigned j = top; j < bottom; j++) begin
          for (int unsigned i = left; i < right; i++) begin
            own_valid[j * w + i] = 1'b1;
            own_id[j * w + i] = wid[WID_W-1:0];
          end
        end
        hit = 1'b1;
      end else if (own_id[idx] == wid[WID_W-1:0]) begin
        hit = 1'b1;
      end else begin
        x++;
        if (x >= w) begin
          x = 0;
          y++;
        end
      end
    end
    if (!hit) begin
      cur_x[wid] = 0;
      cur_y[wid] = h;
      return res;
    end
    cur_x[wid] = x;
    cur_y[wid] = y;
    res.status = ST_GRANT;
    res.tile_x = x[COORD_W-1:0];
    res.tile_y = y[COORD_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) tile_answers_q.push_back(predict_alloc(req));
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (tile_answers_q.size() == 0) begin
        if (errors < 10)
          $display("unexpected word: status %0d x %0d y %0d", rsp.status, rsp.tile_x,
                   rsp.tile_y);
        errors++;
      end else begin
        want = tile_answers_q.pop_front();
        if (rsp.status !== want.status || rsp.tile_x !== want.tile_x ||
            rsp.tile_y !== want.tile_y) begin
          if (errors < 10)
            $display("mismatch: expected status %0d x %0d y %0d, got status %0d x %0d y %0d",
                     want.status, want.tile_x, want.tile_y, rsp.status, rsp.tile_x,
                     rsp.tile_y);
          errors++;
        end
      end
    end
  end

  // response side stalls
  initial begin
    int unsigned stall;
    stall = 0;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall == 0 && hold_cycles != 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else if (stall == 0 && idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 13);
      end
      if (stall != 0) begin
        rsp_ready <= 1'b0;
        stall--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input op_t op, input int unsigned wid);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{operation: op, worker_id: wid[WID_W-1:0]};
    do @(posedge clk); while (!req_ready);
    sent_items++;
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (tile_answers_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_config(input int unsigned w, h, bw, bh);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_GRID_W;
    cfg_data <= w[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_GRID_H;
    cfg_data <= h[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_BLOCK_W;
    cfg_data <= bw[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= REG_BLOCK_H;
    cfg_data <= bh[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    grid_w = w & 32'h7FF;
    grid_h = h & 32'h7FF;
    blk_w = bw & 32'h7FF;
    blk_h = bh & 32'h7FF;
  endtask

  task automatic test_single_tile();
    send_request(OP_CLAIM, 0);
    send_request(OP_CLAIM, 0);
    send_request(OP_CLAIM, 15);
    send_request(OP_NEW_FRAME, 9);
    send_request(OP_CLAIM, 15);
  endtask

  task automatic test_block_sizes();
    drain();
    set_config(3, 2, 0, 0);
    send_request(OP_NEW_FRAME, 0);
    send_request(OP_CLAIM, 1);
    send_request(OP_CLAIM, 2);
    drain();
    set_config(3, 2, 2047, 2047);
    send_request(OP_NEW_FRAME, 15);
    send_request(OP_CLAIM, 1);
    send_request(OP_CLAIM, 2);
  endtask

  task automatic test_grid_limits();
    drain();
    set_config(0, 2047, 1, 1);
    send_request(OP_CLAIM, 3);
    drain();
    set_config(2047, 0, 1, 1);
    send_request(OP_CLAIM, 3);
    drain();
    set_config(2047, 1, 1, 1);
    send_request(OP_CLAIM, 3);
    drain();
    set_config(1024, 1, 1023, 1);
    send_request(OP_NEW_FRAME, 0);
    send_request(OP_CLAIM, 5);
    send_request(OP_CLAIM, 6);
    drain();
    set_config(1, 1024, 1, 1023);
    send_request(OP_NEW_FRAME, 0);
    send_request(OP_CLAIM, 5);
    send_request(OP_CLAIM, 6);
  endtask

  task automatic test_cursor_regrid();
    drain();
    set_config(8, 4, 7, 1);
    send_request(OP_NEW_FRAME, 0);
    send_request(OP_CLAIM, 2);
    send_request(OP_CLAIM, 4);
    drain();
    set_config(2, 4, 1, 1);
    send_request(OP_CLAIM, 4);
    drain();
    set_config(2, 1, 1, 1);
    send_request(OP_CLAIM, 4);
  endtask

  task automatic test_random_claims(input int unsigned target);
    int unsigned w, h, bw, bh, claims, pick, team_size;
    int unsigned team [4];
    while (sent_items < target) begin
      drain();
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        w = $urandom_range(0, 2047);
        h = $urandom_range(0, 2047);
        bw = $urandom_range(0, 2047);
        bh = $urandom_range(0, 2047);
      end else if (pick <= 2) begin
        w = $urandom_range(1, 32);
        h = 1024 / w;
        bw = $urandom_range(0, 64);
        bh = $urandom_range(0, 64);
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
        bw = $urandom_range(0, 9);
        bh = $urandom_range(0, 9);
      end
      set_config(w, h, bw, bh);
      send_request(OP_NEW_FRAME, $urandom_range(0, 15));
      claims = (pick <= 2) ? $urandom_range(4, 10) : $urandom_range(10, 50);
      team_size = $urandom_range(1, 4);
      for (int i = 0; i < 4; i++) team[i] = $urandom_range(0, 15);
      repeat (claims) begin
        pick = $urandom_range(0, 39);
        if (pick == 0) send_request(OP_NEW_FRAME, $urandom_range(0, 15));
        else if (pick == 1) send_request(OP_CLAIM, $urandom_range(0, 15));
        else send_request(OP_CLAIM, team[$urandom_range(0, team_size - 1)]);
      end
    end
  endtask

  task automatic test_backpressure();
    drain();
    set_config(6, 6, 2, 3);
    send_request(OP_NEW_FRAME, 0);
    drain();
    hold_cycles = 400;
    repeat (12) send_request(OP_CLAIM, $urandom_range(0, 15));
    drain();
    repeat (6) send_request(OP_CLAIM, $urandom_range(0, 15));
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_GRID_W;
    cfg_data = '0;
    req_valid = 1'b0;
    req = '0;
    idle_on = 1'b1;
    hold_cycles = 0;
    sent_items = 0;
    errors = 0;
    grid_w = 1;
    grid_h = 1;
    blk_w = 1;
    blk_h = 1;
    clear_frame();
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_single_tile();
    test_block_sizes();
    test_grid_limits();
    test_cursor_regrid();
    test_random_claims(1420);
    test_backpressure();
    idle_on = 1'b0;
    test_random_claims(sent_items + 200);
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
